[hw/rtl/eaod_pkg.sv]
// Shared types, widths and constants of the EMG activity onset detector.
package eaod_pkg;

  // Fixed field widths
  localparam int unsigned IN_FIELDS  = 8;
  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned MAG_W      = 8;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned IN_DATA_W  = IN_FIELDS * SAMPLE_W;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 8;

  // Defaults of the top-level parameters
  localparam int unsigned CHANNELS_DEF   = 8;
  localparam int unsigned WINDOW_LEN_DEF = 8;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Register reset values
  localparam logic [LEVEL_W-1:0] QUIET_LEVEL_RST  = 8'd5;
  localparam logic [LEVEL_W-1:0] ACTIVE_LEVEL_RST = 8'd5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUIET_LEVEL  = 8'd0,
    CFG_ACTIVE_LEVEL = 8'd1
  } cfg_idx_e;

  // Threshold registers as seen by the back end
  typedef struct packed {
    logic [LEVEL_W-1:0] active_level;
    logic [LEVEL_W-1:0] quiet_level;
  } cfg_t;

  // One frame of magnitudes, channel 0 in the lowest bits
  typedef logic [IN_FIELDS-1:0][MAG_W-1:0] mag_frame_t;

  // One result, active in bit 0
  typedef struct packed {
    logic [IN_FIELDS-1:0] cleared_mask;
    logic                 active;
  } result_t;

endpackage

[hw/rtl/eaod_front.sv]
// Front end: takes sample frames and turns them into magnitude frames for the queue.
module eaod_front
  import eaod_pkg::*;
(
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [IN_DATA_W-1:0] s_tdata_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output mag_frame_t           push_data_o
);

  // Request handshake goes straight to the queue
  assign push_valid_o = s_tvalid_i;
  assign s_tready_o   = push_ready_i;

  // Magnitude of each two's complement sample; -128 gives 128
  always_comb begin
    logic [SAMPLE_W-1:0] raw;
    for (int i = 0; i < IN_FIELDS; i++) begin
      raw = s_tdata_i[i*SAMPLE_W +: SAMPLE_W];
      push_data_o[i] = raw[SAMPLE_W-1] ? MAG_W'(~raw + SAMPLE_W'(1)) : MAG_W'(raw);
    end
  end

endmodule

[hw/rtl/eaod_queue.sv]
// Short request queue between the front and back ends.
module eaod_queue
  import eaod_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  mag_frame_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output mag_frame_t pop_data_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  mag_frame_t slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/eaod_back.sv]
// Back end: per-channel window, long-run sum and count, clear decision and result register.
module eaod_back
  import eaod_pkg::*;
#(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  mag_frame_t pop_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output result_t    out_data_o
);

  localparam int unsigned TOT_W = $clog2(128 * WINDOW_LEN + 1);
  localparam int unsigned QW    = LEVEL_W + $clog2(WINDOW_LEN + 1);
  localparam int unsigned PW    = (SUM_W > LEVEL_W + COUNT_BITS) ? SUM_W
                                                                 : LEVEL_W + COUNT_BITS;

  logic advance;
  logic [CHANNELS-1:0] clr_v, act_v;
  logic [QW-1:0] quiet_lim;
  logic out_valid_q;
  result_t out_data_q, out_data_d;

  // A frame moves on when the result register is free or being emptied
  assign advance     = pop_valid_i & (~out_valid_q | out_ready_i);
  assign pop_ready_o = ~out_valid_q | out_ready_i;

  // Quiet threshold scaled by the window length
  assign quiet_lim = QW'(cfg_i.quiet_level) * QW'(WINDOW_LEN);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    logic [MAG_W-1:0] mag;
    logic [WINDOW_LEN-1:0][MAG_W-1:0] win_q, win_d;
    logic [TOT_W-1:0] total_q, total_d;
    logic [SUM_W-1:0] sum_q, sum_d, sum_inc;
    logic [SUM_W:0]   sum_add;
    logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_inc;
    logic [PW-1:0] prod;
    logic quiet, hot;

    // Channels without an input field see a zero sample
    if (c < IN_FIELDS) begin : g_in
      assign mag = pop_data_i[c];
    end else begin : g_zero
      assign mag = '0;
    end

    // Window shift and running window total
    always_comb begin
      win_d[0] = mag;
      for (int i = 1; i < WINDOW_LEN; i++) begin
        win_d[i] = win_q[i-1];
      end
    end
    assign total_d = total_q + TOT_W'(mag) - TOT_W'(win_q[WINDOW_LEN-1]);

    // Saturating long-run sum and count
    assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(mag);
    assign sum_inc = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + COUNT_BITS'(1);

    // Mean tests as multiply-compares; updated count is never zero
    assign prod  = PW'(cfg_i.active_level) * PW'(cnt_inc);
    assign hot   = (PW'(sum_inc) > prod);
    assign quiet = (QW'(total_d) < quiet_lim);

    assign clr_v[c] = quiet & hot;
    assign act_v[c] = hot & ~quiet;

    assign sum_d = clr_v[c] ? '0 : sum_inc;
    assign cnt_d = clr_v[c] ? '0 : cnt_inc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_q   <= '0;
        total_q <= '0;
        sum_q   <= '0;
        cnt_q   <= '0;
      end else if (advance) begin
        win_q   <= win_d;
        total_q <= total_d;
        sum_q   <= sum_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // Result assembly; only channels with an input field report a clear
  for (genvar i = 0; i < IN_FIELDS; i++) begin : g_mask
    if (i < CHANNELS) begin : g_used
      assign out_data_d.cleared_mask[i] = clr_v[i];
    end else begin : g_unused
      assign out_data_d.cleared_mask[i] = 1'b0;
    end
  end
  assign out_data_d.active = |act_v;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hw/rtl/emg_activity_onset_detector.sv]
// Top level of the EMG activity onset detector: ports, threshold registers, front, queue, back.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid_i/tready_o     tdata: sample_0..sample_7, 8 bits each
//   m_axis    out        m_axis_tvalid_o/tready_i     tdata: active, cleared_mask, zero pad
//   cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One frame is taken every cycle while the queue has room. An accepted frame is written
// into the queue, passes to the back end once the result register is free or being emptied,
// and its result is then registered and offered on m_axis. The per-channel sum/count
// update (increment, 8 x COUNT_BITS multiply and compare) is combinational.
// Reset clears the windows, sums, counts, queue and result register; thresholds return to 5.
// A stalled m_axis fills the two-entry queue, after which s_axis_tready_o drops.
module emg_activity_onset_detector
  import eaod_pkg::*;
#(
  parameter int unsigned CHANNELS   = CHANNELS_DEF,
  parameter int unsigned WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // sample_0 [7:0] .. sample_7 [63:56]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // active [0], cleared_mask [8:1], zero [15:9]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [LEVEL_W-1:0]    cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic push_valid, push_ready, pop_valid, pop_ready;
  mag_frame_t push_data, pop_data;
  result_t result;

  // Threshold registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_QUIET_LEVEL:  cfg_d.quiet_level  = cfg_data_i;
        CFG_ACTIVE_LEVEL: cfg_d.active_level = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quiet_level  <= QUIET_LEVEL_RST;
      cfg_q.active_level <= ACTIVE_LEVEL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end
  eaod_front u_front (
    .s_tvalid_i   (s_axis_tvalid_i),
    .s_tready_o   (s_axis_tready_o),
    .s_tdata_i    (s_axis_tdata_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Queue
  eaod_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back end
  eaod_back #(
    .CHANNELS   (CHANNELS),
    .WINDOW_LEN (WINDOW_LEN),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (result)
  );

  assign m_axis_tdata_o = OUT_DATA_W'(result);

endmodule

[hw/rtl/eaod_checker.sv]
// Port-level checks of the EMG activity onset detector, bound to the top level.
module eaod_port_checks
  import eaod_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic [2:0] infl_q, infl_d;
  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;

  // Requests taken but not yet answered
  always_comb begin
    infl_d = infl_q;
    if (in_acc && !out_acc) begin
      infl_d = infl_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      infl_d = infl_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= '0;
    end else begin
      infl_q <= infl_d;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // No result without an outstanding request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> infl_q != 3'd0)
    else $error("result without a request");

  // Backpressure only once the queue is full
  a_full_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> infl_q >= 3'(QUEUE_DEPTH))
    else $error("input stalled with room left");

  // Padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:9] == 7'd0)
    else $error("result padding not zero");

endmodule

bind emg_activity_onset_detector eaod_port_checks u_eaod_port_checks (.*);

[test/eaod_checker.sv]
// Checker for the EMG activity onset detector: follows requests, predicts results, compares.
module eaod_checker
  import eaod_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  frame_valid_i,
  input  logic                  frame_ready_i,
  input  logic [IN_DATA_W-1:0]  frame_data_i,   // sample_0 [7:0] .. sample_7 [63:56]
  input  logic                  result_valid_i,
  input  logic                  result_ready_i,
  input  logic [OUT_DATA_W-1:0] result_data_i,  // active [0], cleared_mask [8:1], zero [15:9]
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [LEVEL_W-1:0]    cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    active_seen_o,
  output int                    clears_seen_o
);

  localparam int unsigned NCH   = CHANNELS_DEF;
  localparam int unsigned WLEN  = WINDOW_LEN_DEF;
  localparam int unsigned CNT_W = COUNT_BITS_DEF;
  localparam int unsigned RES_W = $bits(result_t);
  localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

  // Predicted block state
  logic [LEVEL_W-1:0] quiet_lvl;
  logic [LEVEL_W-1:0] active_lvl;
  logic [MAG_W-1:0]   mag_hist  [NCH][WLEN];   // newest at index 0
  logic [15:0]        win_total [NCH];
  logic [SUM_W-1:0]   run_sum   [NCH];
  logic [CNT_W-1:0]   smp_count [NCH];

  // Onset results awaiting the output side, oldest first
  result_t onsets_due [$];
  result_t got;
  result_t want;
  int      fails;
  int      checked;
  int      n_active;
  int      n_clears;

  initial begin
    fails    = 0;
    checked  = 0;
    n_active = 0;
    n_clears = 0;
  end

  function automatic logic [MAG_W-1:0] rectify(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W:0] neg;
    neg = 9'h100 - {1'b0, s};
    if (s[SAMPLE_W-1]) return neg[MAG_W-1:0];   // 0x80 gives 128
    return s;
  endfunction

  // Long-run mean above the active level, as a multiply-compare
  function automatic bit sustained_activity(input int c);
    if (smp_count[c] == '0) return 1'b0;
    return 64'(run_sum[c]) > 64'(active_lvl) * 64'(smp_count[c]);
  endfunction

  // Push one frame through every channel and work out its result
  function automatic result_t advance_channels(input logic [IN_DATA_W-1:0] frame);
    result_t          r;
    logic [MAG_W-1:0] mag;
    logic [MAG_W-1:0] oldest;
    logic [SUM_W:0]   sum_ext;
    int               c;
    int               k;
    r = '0;
    for (c = 0; c < NCH; c++) begin
      mag    = (c < IN_FIELDS) ? rectify(frame[c*SAMPLE_W +: SAMPLE_W]) : '0;
      oldest = mag_hist[c][WLEN-1];
      for (k = WLEN - 1; k > 0; k--) mag_hist[c][k] = mag_hist[c][k-1];
      mag_hist[c][0] = mag;
      win_total[c]   = win_total[c] - 16'(oldest) + 16'(mag);
      // saturating long-run sum and count
      sum_ext    = {1'b0, run_sum[c]} + (SUM_W+1)'(mag);
      run_sum[c] = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (smp_count[c] != COUNT_SAT) smp_count[c]++;
      // quiet window after a loud stretch clears the channel
      if (32'(win_total[c]) < 32'(quiet_lvl) * WLEN && sustained_activity(c)) begin
        run_sum[c]   = '0;
        smp_count[c] = '0;
        if (c < IN_FIELDS) r.cleared_mask[c] = 1'b1;
      end
    end
    for (c = 0; c < NCH; c++) begin
      if (sustained_activity(c)) r.active = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_lvl  = QUIET_LEVEL_RST;
      active_lvl = ACTIVE_LEVEL_RST;
      for (int c = 0; c < NCH; c++) begin
        for (int k = 0; k < WLEN; k++) mag_hist[c][k] = '0;
        win_total[c] = '0;
        run_sum[c]   = '0;
        smp_count[c] = '0;
      end
      onsets_due.delete();
    end else begin
      // results first: none can belong to a frame taken at this same edge
      if (result_valid_i && result_ready_i) begin
        got = result_t'(result_data_i[RES_W-1:0]);
        if (onsets_due.size() == 0) begin
          fails++;
          $display("%0t: result with none due, expected nothing, got active %0b mask %02h",
                   $time, got.active, got.cleared_mask);
        end else begin
          want = onsets_due.pop_front();
          checked++;
          if (got.active !== want.active) begin
            fails++;
            $display("%0t: active mismatch, expected %0b, got %0b",
                     $time, want.active, got.active);
          end
          if (got.cleared_mask !== want.cleared_mask) begin
            fails++;
            $display("%0t: cleared_mask mismatch, expected %02h, got %02h",
                     $time, want.cleared_mask, got.cleared_mask);
          end
          if (result_data_i[OUT_DATA_W-1:RES_W] !== '0) begin
            fails++;
            $display("%0t: padding mismatch, expected 0, got %0h",
                     $time, result_data_i[OUT_DATA_W-1:RES_W]);
          end
        end
      end

      // threshold writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_QUIET_LEVEL:  quiet_lvl  = cfg_data_i;
          CFG_ACTIVE_LEVEL: active_lvl = cfg_data_i;
          default: ;
        endcase
      end

      if (frame_valid_i && frame_ready_i) begin
        want = advance_channels(frame_data_i);
        onsets_due.push_back(want);
        n_active += want.active;
        n_clears += $countones(want.cleared_mask);
      end
    end

    fail_count_o  <= fails;
    pending_o     <= onsets_due.size();
    checked_o     <= checked;
    active_seen_o <= n_active;
    clears_seen_o <= n_clears;
  end

endmodule

[test/tb_top.sv]
// Testbench top of the EMG activity onset detector: stimulus, threshold phases and verdict.
module tb_top;
  import eaod_pkg::*;

  localparam int FRAMES_PER_PHASE = 125;
  localparam int PHASES           = 7;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SQUEEZE_CYCLES   = 64;
  localparam int SETTLE_CYCLES    = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'hA5;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_MOSTLY,
    RX_RUNS
  } rx_mode_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  s_valid     = 1'b0;
  logic [IN_DATA_W-1:0]  s_data      = '0;
  logic                  m_ready     = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [LEVEL_W-1:0]    cfg_data    = '0;
  logic                  s_ready;
  logic                  m_valid;
  logic [OUT_DATA_W-1:0] m_data;
  logic                  cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int active_seen;
  int clears_seen;
  int frames_sent  = 0;
  int burst_left   = 0;
  int cycles       = 0;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  emg_activity_onset_detector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  eaod_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .frame_valid_i  (s_valid),
    .frame_ready_i  (s_ready),
    .frame_data_i   (s_data),
    .result_valid_i (m_valid),
    .result_ready_i (m_ready),
    .result_data_i  (m_data),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .active_seen_o  (active_seen),
    .clears_seen_o  (clears_seen)
  );

  // Output side back-pressure: changing modes, plus one long hold-off on request
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       stall_left;
    mode       = RX_OPEN;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        m_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk_i);
        squeeze_done = 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_ready <= 1'b1;
          RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_ready <= 1'b0;
            end else begin
              m_ready <= 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
            end
          end
        endcase
      end
    end
  end

  // Offer one frame and wait for its request to be taken; bursts with gaps between
  task automatic push_frame(input logic [IN_DATA_W-1:0] f);
    s_valid <= 1'b1;
    s_data  <= f;
    do @(posedge clk_i); while (!s_ready);
    frames_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(0, 10);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle_block();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Signed sample with magnitude up to amp
  function automatic logic [SAMPLE_W-1:0] shaped_sample(input int amp);
    int mag;
    bit neg;
    mag = $urandom_range(0, amp);
    neg = 1'($urandom_range(0, 1));
    if (neg || mag == 128) return SAMPLE_W'(256 - mag);
    return SAMPLE_W'(mag);
  endfunction

  // Mostly loud or quiet stretches per channel, some raw noise frames
  task automatic random_frames(input int n);
    int                   done_n;
    int                   len;
    int                   amp [IN_FIELDS];
    bit                   shaped;
    logic [IN_DATA_W-1:0] f;
    done_n = 0;
    while (done_n < n) begin
      shaped = ($urandom_range(0, 9) < 7);
      len    = shaped ? $urandom_range(4, 24) : $urandom_range(1, 6);
      for (int c = 0; c < IN_FIELDS; c++)
        amp[c] = $urandom_range(0, 1) ? $urandom_range(0, 128) : $urandom_range(0, 8);
      for (int k = 0; k < len; k++) begin
        for (int c = 0; c < IN_FIELDS; c++)
          f[c*SAMPLE_W +: SAMPLE_W] = shaped ? shaped_sample(amp[c]) : SAMPLE_W'($urandom);
        push_frame(f);
        done_n++;
      end
    end
  endtask

  initial begin
    logic [LEVEL_W-1:0] quiet_set  [PHASES];
    logic [LEVEL_W-1:0] active_set [PHASES];
    quiet_set  = '{8'd0, 8'd128, 8'd255, 8'd0,   8'd255, 8'd20, 8'd1};
    active_set = '{8'd0, 8'd128, 8'd255, 8'd255, 8'd0,   8'd8,  8'd40};

    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed frames at reset thresholds: extremes, then a loud stretch on even
    // channels followed by silence so that they get cleared
    push_frame({8{8'h00}});
    push_frame({8{8'h7F}});
    push_frame({8{8'h80}});
    push_frame({8{8'hFF}});
    push_frame({4{8'hFE, 8'h01}});
    repeat (8) push_frame({4{8'h03, 8'h9C}});
    repeat (8) push_frame({8{8'h00}});
    random_frames(FRAMES_PER_PHASE);
    settle_block();

    // Threshold phases, extremes included
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_QUIET_LEVEL, quiet_set[p]);
      write_reg(CFG_ACTIVE_LEVEL, active_set[p]);
      if (p == 3) write_reg(CFG_IDX_SPARE, 8'h00);
      if (p == 1) squeeze_req = 1'b1;
      random_frames(FRAMES_PER_PHASE);
      settle_block();
    end

    $display("Sent %0d frames over %0d threshold settings, %0d results checked.",
             frames_sent, PHASES + 1, checked);
    $display("Predicted %0d active results and %0d channel clears.", active_seen, clears_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[emg_activity_onset_detector.f]
hw/rtl/eaod_pkg.sv
hw/rtl/eaod_front.sv
hw/rtl/eaod_queue.sv
hw/rtl/eaod_back.sv
hw/rtl/emg_activity_onset_detector.sv
hw/rtl/eaod_checker.sv
test/eaod_checker.sv
test/tb_top.sv
